// ===== rtl/qsl_pkg.sv =====
// ----------------------------------------------------------------------------
// qsl_pkg: shared definitions for the quicksort sorter
// Holds the sizes of the element store and range stack, and the range type.
// ----------------------------------------------------------------------------
`default_nettype none

package qsl_pkg;

    localparam int MAX_ITEMS   = 64;                  // values held per set
    localparam int STORE_DEPTH = 64;
    localparam int STACK_DEPTH = 64;
    localparam int VALUE_W     = 32;
    localparam int IDX_W       = $clog2(STORE_DEPTH); // index into the store
    localparam int CNT_W       = IDX_W + 1;           // count up to the depth
    localparam int SP_W        = $clog2(STACK_DEPTH) + 1;
    localparam int RANGE_W     = 2 * IDX_W;

    // One entry of the range stack, high index in the upper half.
    typedef struct packed {
        logic [IDX_W-1:0] hi;
        logic [IDX_W-1:0] lo;
    } t_range;

endpackage

`default_nettype wire

// ===== rtl/qsl_ram.sv =====
// ----------------------------------------------------------------------------
// qsl_ram: simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module qsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/quicksort_lomuto.sv =====
// ----------------------------------------------------------------------------
// quicksort_lomuto: stream sorter using quicksort with Lomuto partitioning
// Collects a set of signed values, sorts it in place and streams it back out.
// ----------------------------------------------------------------------------
// Each request on the slave side carries one signed 32-bit value; it is written
// into a 64-entry element store. The request with tlast set closes the set: the
// block then drops s_axis_tready and sorts the store in place by quicksort,
// taking the last element of a range as the pivot and moving values less than
// or equal to it to the left. Pending ranges live in a 64-entry range stack
// instead of recursion. A single signed comparator and one store port pair do
// all the work under a small sequencer: each element visited in a partition
// pass is compared with the pivot, and each one found less than or equal to it
// is swapped into place with two store writes. The store's registered read
// port paces the output: each sorted value is read, loaded into the output
// register and held until the sink takes it, and the next value is not read
// before then. The final value carries tlast. Values arriving once 64 are held
// are dropped, and m_axis_tuser is then high on every result of that set. After
// the last result is taken the block is ready for the next set.
// ----------------------------------------------------------------------------
`default_nettype none

module quicksort_lomuto (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave side
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value_in
    input  wire logic        s_axis_tlast,   // last_in
    // Master side
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [31:0] value_out
    output logic             m_axis_tlast,   // last_out
    output logic             m_axis_tuser    // [0] overflow
);

    import qsl_pkg::*;

    typedef enum logic [14:0] {
        S_LOAD  = 15'b000000000000001,  // taking values
        S_START = 15'b000000000000010,  // push the whole range
        S_POP   = 15'b000000000000100,  // pop a range or finish
        S_POPW  = 15'b000000000001000,  // range read back, fetch pivot
        S_PIV   = 15'b000000000010000,  // latch pivot, fetch first element
        S_CMP   = 15'b000000000100000,  // compare element with pivot
        S_SWP   = 15'b000000001000000,  // swap, first write
        S_SWP2  = 15'b000000010000000,  // swap, second write
        S_FIN   = 15'b000000100000000,  // fetch pivot's final slot
        S_FW1   = 15'b000001000000000,  // move that value to the top
        S_FW2   = 15'b000010000000000,  // place pivot, push left part
        S_PUSH2 = 15'b000100000000000,  // push right part
        S_ORD   = 15'b001000000000000,  // read next sorted value
        S_OWT   = 15'b010000000000000,  // load output register
        S_OHS   = 15'b100000000000000   // wait for the sink
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]   r_count, n_count;
    logic [SP_W-1:0]    r_sp, n_sp;
    logic               r_dropped, n_dropped;
    logic [IDX_W-1:0]   r_lo, n_lo, r_hi, n_hi, r_st, n_st, r_j, n_j, r_k, n_k;
    logic [VALUE_W-1:0] r_pivot, n_pivot, r_vj, n_vj;
    logic [VALUE_W-1:0] r_out_data, n_out_data;
    logic               r_out_valid, n_out_valid, r_out_last, n_out_last;

    // Store ports
    logic               st_we;
    logic [IDX_W-1:0]   st_waddr, st_raddr;
    logic [VALUE_W-1:0] st_wdata, st_rdata;
    // Stack ports
    logic               sk_we;
    logic [IDX_W-1:0]   sk_waddr, sk_raddr;
    t_range             sk_wdata, sk_rdata;

    logic               le_pivot;
    logic [IDX_W-1:0]   j_next;
    logic               push_left, push_right, stack_room;

    qsl_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    qsl_ram #(.WIDTH(RANGE_W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (sk_we),
        .i_waddr (sk_waddr),
        .i_wdata (sk_wdata),
        .i_raddr (sk_raddr),
        .o_rdata (sk_rdata)
    );

    // The one shared comparator: current element against the pivot.
    assign le_pivot = ($signed(st_rdata) <= $signed(r_pivot));
    assign j_next   = r_j + IDX_W'(1);

    // Child ranges around the pivot's final index r_st.
    assign push_left  = ({1'b0, r_st} > ({1'b0, r_lo} + CNT_W'(1)));
    assign push_right = (({1'b0, r_st} + CNT_W'(1)) < {1'b0, r_hi});
    assign stack_room = (r_sp < SP_W'(STACK_DEPTH));

    assign s_axis_tready = (r_state == S_LOAD);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_dropped;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sp        = r_sp;
        n_dropped   = r_dropped;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_st        = r_st;
        n_j         = r_j;
        n_k         = r_k;
        n_pivot     = r_pivot;
        n_vj        = r_vj;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;

        st_we    = 1'b0;
        st_waddr = r_count[IDX_W-1:0];
        st_wdata = s_axis_tdata;
        st_raddr = r_st;
        sk_we    = 1'b0;
        sk_waddr = r_sp[IDX_W-1:0];
        sk_wdata = '{hi: r_st - IDX_W'(1), lo: r_lo};
        sk_raddr = r_sp[IDX_W-1:0] - IDX_W'(1);

        unique case (r_state)
            S_LOAD: begin
                if (s_axis_tvalid) begin
                    if (r_count < CNT_W'(MAX_ITEMS)) begin
                        st_we   = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_k = '0;
                if (r_count < CNT_W'(2)) begin
                    n_state = S_ORD;
                end else begin
                    sk_we    = 1'b1;
                    sk_waddr = '0;
                    sk_wdata = '{hi: IDX_W'(r_count - CNT_W'(1)), lo: '0};
                    n_sp     = SP_W'(1);
                    n_state  = S_POP;
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    n_state = S_ORD;
                end else begin
                    n_sp    = r_sp - SP_W'(1);
                    n_state = S_POPW;
                end
            end
            S_POPW: begin
                n_lo = sk_rdata.lo;
                n_hi = sk_rdata.hi;
                st_raddr = sk_rdata.hi;
                if (sk_rdata.lo >= sk_rdata.hi) begin
                    n_state = S_POP;
                end else begin
                    n_state = S_PIV;
                end
            end
            S_PIV: begin
                n_pivot  = st_rdata;
                n_st     = r_lo;
                n_j      = r_lo;
                st_raddr = r_lo;
                n_state  = S_CMP;
            end
            S_CMP: begin
                if (le_pivot) begin
                    n_vj     = st_rdata;
                    st_raddr = r_st;
                    n_state  = S_SWP;
                end else begin
                    n_j      = j_next;
                    st_raddr = j_next;
                    n_state  = (j_next == r_hi) ? S_FIN : S_CMP;
                end
            end
            S_SWP: begin
                st_we    = 1'b1;
                st_waddr = r_j;
                st_wdata = st_rdata;
                n_state  = S_SWP2;
            end
            S_SWP2: begin
                st_we    = 1'b1;
                st_waddr = r_st;
                st_wdata = r_vj;
                n_st     = r_st + IDX_W'(1);
                n_j      = j_next;
                st_raddr = j_next;
                n_state  = (j_next == r_hi) ? S_FIN : S_CMP;
            end
            S_FIN: begin
                st_raddr = r_st;
                n_state  = S_FW1;
            end
            S_FW1: begin
                st_we    = 1'b1;
                st_waddr = r_hi;
                st_wdata = st_rdata;
                n_state  = S_FW2;
            end
            S_FW2: begin
                st_we    = 1'b1;
                st_waddr = r_st;
                st_wdata = r_pivot;
                if (push_left && stack_room) begin
                    sk_we = 1'b1;
                    n_sp  = r_sp + SP_W'(1);
                end
                n_state = S_PUSH2;
            end
            S_PUSH2: begin
                sk_wdata = '{hi: r_hi, lo: r_st + IDX_W'(1)};
                if (push_right && stack_room) begin
                    sk_we = 1'b1;
                    n_sp  = r_sp + SP_W'(1);
                end
                n_state = S_POP;
            end
            S_ORD: begin
                st_raddr = r_k;
                n_state  = S_OWT;
            end
            S_OWT: begin
                n_out_data  = st_rdata;
                n_out_valid = 1'b1;
                n_out_last  = ({1'b0, r_k} + CNT_W'(1) == r_count);
                n_state     = S_OHS;
            end
            S_OHS: begin
                if (m_axis_tready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_count   = '0;
                        n_sp      = '0;
                        n_dropped = 1'b0;
                        n_state   = S_LOAD;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_sp        <= '0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sp        <= n_sp;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_st       <= n_st;
        r_j        <= n_j;
        r_k        <= n_k;
        r_pivot    <= n_pivot;
        r_vj       <= n_vj;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    // The result is only valid while the sequencer waits on the sink.
    a_valid_in_ohs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_OHS))
        else $error("result valid outside the output wait state");

    // The store never holds more than its capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ITEMS))
        else $error("element count beyond capacity");

    // The stack pointer stays within the stack.
    a_sp_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("range stack pointer beyond depth");

    // During a partition pass the insertion slot trails the scan below the pivot.
    a_part_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CMP) || (r_state == S_SWP) || (r_state == S_SWP2))
            |-> ((r_st <= r_j) && (r_j < r_hi)))
        else $error("partition indices out of order");

    // Taking the final result empties the set for the next one.
    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast)
            |=> ((r_count == '0) && !r_dropped && (r_state == S_LOAD)))
        else $error("set not cleared after final result");

endmodule

`default_nettype wire
